// ----- rtl/cpf_pkg.sv -----
// Package for the clip player with linear fades: item types, register codes, sizes.
// No dependencies.
package cpf_pkg;

	localparam int CLIP_FRAMES  = 65536;
	localparam int MAX_CHANNELS = 2;
	localparam int FRAME_W      = $clog2(CLIP_FRAMES);
	localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int STORE_DEPTH  = CLIP_FRAMES * MAX_CHANNELS;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int LEN_W        = FRAME_W + 1;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_RENDER = 2'd1,
		OP_LOCATE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_START    = 3'd0,
		REG_END      = 3'd1,
		REG_FADE_IN  = 3'd2,
		REG_FADE_OUT = 3'd3,
		REG_GAIN     = 3'd4,
		REG_CLIP_LEN = 3'd5,
		REG_CLIP_CH  = 3'd6,
		REG_OUT_CH   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [15:0]        load_frame;
		logic [2:0]         load_channel;
		logic signed [15:0] load_sample;
		logic [31:0]        new_position;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         out_channel;
		logic signed [15:0] out_sample;
		logic               written;
		logic               last;
	} out_item_t;

	// Classified render job handed from the front part to the back part.
	typedef struct packed {
		logic               active;
		logic [FRAME_W-1:0] frame;
		logic               do_in;
		logic [31:0]        in_num;
		logic [31:0]        in_den;
		logic               do_out;
		logic [31:0]        out_num;
		logic [31:0]        out_den;
		logic [3:0]         nout;
		logic [3:0]         cch;
		logic signed [15:0] gain;
	} job_t;

endpackage

// ----- rtl/cpf_front.sv -----
// Front part: accepts items, holds position and configuration, classifies renders.
// Depends on cpf_pkg.
module cpf_front import cpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic       cfg_we,
	output job_t       job,
	output logic       job_push,
	input  logic       job_full,
	input  logic       render_busy,
	output logic       ld_we,
	output logic [ADDR_W-1:0] ld_addr,
	output logic signed [15:0] ld_data
);

	logic [31:0] start_q, end_q, fin_q, fout_q, pos_q;
	logic signed [15:0] gain_q;
	logic [16:0] clen_q;
	logic [3:0]  cch_q, nout_q;
	logic        acc;

	// Widened window arithmetic
	logic [32:0] st, en, len, eff_end, win, fin, fout, pos, ein;
	logic [3:0]  cch_c;
	logic        active;

	// Hold a load until every earlier render has read clip memory.
	assign in_stall = job_full
		|| ((op_t'(in_item.operation) == OP_LOAD) && render_busy);
	assign acc = in_valid && !in_stall;

	always_comb begin
		st  = {1'b0, start_q};
		en  = (end_q > start_q) ? {1'b0, end_q} : {1'b0, start_q};
		len = (clen_q < 17'(CLIP_FRAMES)) ? 33'(clen_q) : 33'(CLIP_FRAMES);
		eff_end = ((st + len) < en) ? st + len : en;
		pos = {1'b0, pos_q};
		cch_c = (cch_q < 4'(MAX_CHANNELS)) ? cch_q : 4'(MAX_CHANNELS);
		active = (len != 33'd0) && (cch_c != 4'd0) && (pos >= st) && (pos < eff_end);
		win  = eff_end - st;
		fin  = ({1'b0, fin_q} < win) ? {1'b0, fin_q} : win;
		fout = ({1'b0, fout_q} < win) ? {1'b0, fout_q} : win;
		ein  = eff_end - pos - 33'd1;
		job.active  = active;
		job.frame   = FRAME_W'(pos - st);
		job.do_in   = active && (fin != 33'd0) && (pos < st + fin);
		job.in_num  = 32'(pos - st);
		job.in_den  = 32'(fin);
		job.do_out  = active && (fout != 33'd0) && (pos >= eff_end - fout);
		job.out_num = 32'(ein);
		job.out_den = 32'(fout);
		job.nout    = (nout_q > 4'd8) ? 4'd8 : nout_q;
		job.cch     = cch_c;
		job.gain    = gain_q;
	end

	assign job_push = acc && (op_t'(in_item.operation) == OP_RENDER);
	assign ld_we = acc && (op_t'(in_item.operation) == OP_LOAD)
		&& (32'(in_item.load_frame) < 32'(CLIP_FRAMES))
		&& (32'(in_item.load_channel) < 32'(MAX_CHANNELS));
	assign ld_addr = ADDR_W'(32'(in_item.load_frame) * 32'(MAX_CHANNELS)
		+ 32'(in_item.load_channel));
	assign ld_data = in_item.load_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0; end_q <= '0; fin_q <= '0; fout_q <= '0;
			gain_q <= 16'sd4096; clen_q <= '0; cch_q <= '0; nout_q <= 4'd2;
			pos_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_index))
					REG_START:    start_q <= cfg_data;
					REG_END:      end_q   <= cfg_data;
					REG_FADE_IN:  fin_q   <= cfg_data;
					REG_FADE_OUT: fout_q  <= cfg_data;
					REG_GAIN:     gain_q  <= cfg_data[15:0];
					REG_CLIP_LEN: clen_q  <= cfg_data[16:0];
					REG_CLIP_CH:  cch_q   <= cfg_data[3:0];
					REG_OUT_CH:   nout_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (acc) begin
				case (op_t'(in_item.operation))
					OP_RENDER: pos_q <= pos_q + 32'd1;
					OP_LOCATE: pos_q <= in_item.new_position;
					default: ;
				endcase
			end
		end
	end

	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full) else $error("render pushed into full queue");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld_we |-> !render_busy) else $error("load while renders outstanding");

endmodule

// ----- rtl/cpf_queue.sv -----
// Short job queue between front and back parts.
// Depends on cpf_pkg.
module cpf_queue import cpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t push_job,
	input  logic push,
	output logic full,
	output job_t pop_job,
	input  logic pop,
	output logic nonempty
);

	job_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (pop && nonempty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && nonempty);
		end
	end

	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		!nonempty |-> cnt_q == '0) else $error("count broken");
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue overflow");
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push lost");

endmodule

// ----- rtl/cpf_back.sv -----
// Back part: divides fade ramps, reads clip memory, scales and emits channel items.
// Depends on cpf_pkg; holds the clip memory.
module cpf_back import cpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t job,
	input  logic job_valid,
	output logic job_pop,
	output logic busy,
	input  logic ld_we,
	input  logic [ADDR_W-1:0] ld_addr,
	input  logic signed [15:0] ld_data,
	output out_item_t out_item,
	output logic out_valid,
	input  logic out_stall
);

	typedef enum logic [2:0] {
		S_IDLE, S_DIV_IN, S_DIV_OUT, S_RAMP, S_READ, S_MUL1, S_MUL2, S_EMIT
	} state_t;

	logic signed [15:0] store [STORE_DEPTH];
	logic signed [15:0] rd_q;

	state_t state_q;
	job_t   job_q;
	logic [48:0] rem_q;
	logic [47:0] quo_q;
	logic [5:0]  bit_q;
	logic [16:0] rin_q, rout_q;
	logic        zero_q, in_phase_q;
	logic [2:0]  ch_q;
	logic [31:0] mag1_q;
	logic [32:0] rr_q;
	logic [62:0] mag2_q;
	logic        neg_q;
	logic        rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [2:0]  src;
	logic [48:0] trial;
	logic [31:0] den;
	logic [15:0] ms, mg;
	logic [62:0] rnd;
	logic [15:0] sat;
	logic [16:0] ramp;

	always_comb begin
		if (job_q.cch == 4'd1) src = 3'd0;
		else if (4'(ch_q) < job_q.cch - 4'd1) src = ch_q;
		else src = 3'(job_q.cch - 4'd1);
		rd_addr = ADDR_W'(32'(job_q.frame) * 32'(MAX_CHANNELS) + 32'(src));
		rd_en = (state_q == S_READ);
		den = (state_q == S_DIV_IN) ? job_q.in_den - 32'd1 : job_q.out_den - 32'd1;
		trial = {rem_q[47:0], quo_q[47]};
		ramp = zero_q ? 17'd0 : quo_q[16:0];
		ms = rd_q[15] ? 16'(-rd_q) : rd_q;
		mg = job_q.gain[15] ? 16'(-job_q.gain) : job_q.gain;
		rnd = (mag2_q + 63'(64'd1 << 43)) >> 44;
		if (neg_q) sat = (rnd > 63'd32768) ? 16'h8000 : 16'(-rnd);
		else       sat = (rnd > 63'd32767) ? 16'h7FFF : rnd[15:0];
	end

	always_ff @(posedge clk) begin
		if (ld_we) store[ld_addr] <= ld_data;
		if (rd_en) rd_q <= store[rd_addr];
	end

	assign job_pop = (state_q == S_IDLE) && job_valid;
	assign busy = (state_q != S_IDLE);

	// One quotient bit per cycle: floor(num * 65536 / den), den = len - 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						ch_q <= '0;
						rin_q <= 17'h10000;
						rout_q <= 17'h10000;
						rem_q <= '0;
						bit_q <= 6'd48;
						quo_q <= job.do_in ? {job.in_num, 16'h0} : {job.out_num, 16'h0};
						if (job.nout == 4'd0) state_q <= S_IDLE;
						else if (job.do_in) state_q <= S_DIV_IN;
						else state_q <= job.do_out ? S_DIV_OUT : S_READ;
					end
				end
				S_DIV_IN, S_DIV_OUT: begin
					in_phase_q <= (state_q == S_DIV_IN);
					zero_q <= (den == 32'd0);
					if (den == 32'd0) begin
						state_q <= S_RAMP;
					end else begin
						if (trial >= 49'(den)) begin
							rem_q <= trial - 49'(den);
							quo_q <= {quo_q[46:0], 1'b1};
						end else begin
							rem_q <= trial;
							quo_q <= {quo_q[46:0], 1'b0};
						end
						bit_q <= bit_q - 6'd1;
						if (bit_q == 6'd1)
							state_q <= S_RAMP;
					end
				end
				S_RAMP: begin
					// Latch the ramp; after the fade-in one, start the fade-out division if the job has one.
					if (in_phase_q) begin
						rin_q <= ramp;
						rem_q <= '0;
						bit_q <= 6'd48;
						quo_q <= {job_q.out_num, 16'h0};
						state_q <= job_q.do_out ? S_DIV_OUT : S_READ;
					end else begin
						rout_q <= ramp;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_MUL1;
				S_MUL1: begin
					mag1_q <= 32'(ms) * 32'(mg);
					rr_q <= 33'(rin_q) * 33'(rout_q);
					neg_q <= rd_q[15] ^ job_q.gain[15];
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					mag2_q <= 63'(mag1_q) * 63'(rr_q);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid || !out_stall) begin
						if (!out_valid) begin
							out_valid <= 1'b1;
							out_item.out_channel <= ch_q;
							out_item.out_sample <= job_q.active ? sat : 16'sd0;
							out_item.written <= job_q.active;
							out_item.last <= (4'(ch_q) + 4'd1 == job_q.nout);
						end
					end
					if (out_valid && !out_stall) begin
						out_valid <= 1'b0;
						if (4'(ch_q) + 4'd1 == job_q.nout) state_q <= S_IDLE;
						else begin
							ch_q <= ch_q + 3'd1;
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_EMIT) else $error("result outside emit");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("pop of empty queue");
	a_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		rin_q <= 17'h10000) else $error("ramp above one");

endmodule

// ----- rtl/clip_player_with_linear_fades.sv -----
// Top level of the clip player with linear fades.
// Depends on cpf_pkg, cpf_front, cpf_queue, cpf_back.
//
// channel  | handshake            | payload
// in       | in_valid / in_stall  | in_item (in_item_t)
// out      | out_valid / out_stall| out_item (out_item_t)
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A render on the back part pops the job, runs up to two 48-step ramp divisions, each
// followed by a latch state, then for each output channel reads, multiplies twice,
// presents and hands off an item; output stalls can hold it.
// Reset sets registers to their defaults and clears position and queue; clip memory is undefined until loaded.
// Input stalls while the four-entry render queue is full; a load also waits until
// every earlier render has finished.
module clip_player_with_linear_fades import cpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  logic       in_valid,
	output logic       in_stall,
	output out_item_t  out_item,
	output logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic       cfg_valid,
	output logic       cfg_ready
);

	job_t push_job, pop_job;
	logic push, full, pop, nonempty, ld_we, back_busy;
	logic [ADDR_W-1:0] ld_addr;
	logic signed [15:0] ld_data;

	assign cfg_ready = 1'b1;

	cpf_front u_front (
		.clk, .arst_n, .in_item, .in_valid, .in_stall,
		.cfg_index, .cfg_data, .cfg_we(cfg_valid && cfg_ready),
		.job(push_job), .job_push(push), .job_full(full),
		.render_busy(nonempty || back_busy),
		.ld_we, .ld_addr, .ld_data
	);

	cpf_queue u_queue (
		.clk, .arst_n, .push_job, .push, .full,
		.pop_job, .pop, .nonempty
	);

	cpf_back u_back (
		.clk, .arst_n, .job(pop_job), .job_valid(nonempty), .job_pop(pop),
		.busy(back_busy),
		.ld_we, .ld_addr, .ld_data, .out_item, .out_valid, .out_stall
	);

endmodule

// ----- tb/sv/clip_player_with_linear_fades_checker.sv -----
// Checker for the clip player: watches the input, output and register channels,
// predicts every output item and compares it field by field. Depends on cpf_pkg.
module clip_player_with_linear_fades_checker import cpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_item,
	input  logic        in_valid,
	input  logic        in_stall,
	input  out_item_t   out_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	output int          pending,
	output int          fails
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned RAMP_ONE = 65536;

	logic [31:0] start_fr, end_fr, fade_in, fade_out;
	logic [15:0] gain_q;
	logic [16:0] clip_len;
	logic [3:0]  clip_ch, out_ch;
	logic [31:0] position;
	logic signed [15:0] clip_mem [int];
	out_item_t   expected_samples [$];

	function automatic longint unsigned fade_ramp(longint unsigned num, longint unsigned len);
		if (len <= 1)
			return 0;
		return (num * RAMP_ONE) / (len - 1);
	endfunction

	function automatic logic [15:0] scaled(logic signed [15:0] smp, logic signed [15:0] g,
			longint unsigned rin, longint unsigned rout);
		bit neg;
		longint unsigned ms, mg, mag;
		neg = (smp < 0) != (g < 0);
		ms = (smp < 0) ? -longint'(smp) : longint'(smp);
		mg = (g < 0) ? -longint'(g) : longint'(g);
		mag = ms * mg * rin * rout;
		mag = (mag + (64'd1 << 43)) >> 44;
		if (neg) begin
			if (mag > 32768)
				mag = 32768;
			return 16'(-longint'(mag));
		end
		if (mag > 32767)
			mag = 32767;
		return 16'(mag);
	endfunction

	task automatic predict_frame_samples();
		int nout, cch, src;
		longint unsigned ln, st, en, eff, win, fin, fout, rin, rout, pos, fr;
		bit active;
		out_item_t o;
		logic signed [15:0] smp;
		nout = (out_ch > 8) ? 8 : out_ch;
		ln = (clip_len < CLIP_FRAMES) ? clip_len : CLIP_FRAMES;
		cch = (clip_ch < MAX_CHANNELS) ? clip_ch : MAX_CHANNELS;
		pos = position;
		st = start_fr;
		en = (end_fr > start_fr) ? end_fr : start_fr;
		eff = (st + ln < en) ? st + ln : en;
		active = ln != 0 && cch != 0 && pos >= st && pos < eff;
		rin = RAMP_ONE;
		rout = RAMP_ONE;
		fr = 0;
		if (active) begin
			win = eff - st;
			fin = (fade_in < win) ? fade_in : win;
			fout = (fade_out < win) ? fade_out : win;
			fr = pos - st;
			if (fin > 0 && pos < st + fin)
				rin = fade_ramp(fr, fin);
			if (fout > 0 && pos >= eff - fout)
				rout = fade_ramp(eff - pos - 1, fout);
		end
		for (int c = 0; c < nout; c++) begin
			o = '0;
			o.out_channel = 3'(c);
			o.last = (c + 1 == nout);
			o.written = active;
			if (active) begin
				src = (cch == 1) ? 0 : ((c < cch - 1) ? c : cch - 1);
				smp = clip_mem.exists(int'(fr) * MAX_CHANNELS + src) ?
					clip_mem[int'(fr) * MAX_CHANNELS + src] : '0;
				o.out_sample = scaled(smp, gain_q, rin, rout);
			end
			expected_samples.push_back(o);
		end
		position <= position + 32'd1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_fr <= '0;
			end_fr <= '0;
			fade_in <= '0;
			fade_out <= '0;
			gain_q <= 16'd4096;
			clip_len <= '0;
			clip_ch <= '0;
			out_ch <= 4'd2;
			position <= '0;
			fails <= 0;
			pending <= 0;
			expected_samples.delete();
		end else begin
			int errs;
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_START:    start_fr <= cfg_data;
					REG_END:      end_fr <= cfg_data;
					REG_FADE_IN:  fade_in <= cfg_data;
					REG_FADE_OUT: fade_out <= cfg_data;
					REG_GAIN:     gain_q <= cfg_data[15:0];
					REG_CLIP_LEN: clip_len <= cfg_data[16:0];
					REG_CLIP_CH:  clip_ch <= cfg_data[3:0];
					REG_OUT_CH:   out_ch <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (op_t'(in_item.operation))
					OP_LOAD: begin
						if (in_item.load_channel < MAX_CHANNELS)
							clip_mem[int'(in_item.load_frame) * MAX_CHANNELS +
								int'(in_item.load_channel)] = in_item.load_sample;
					end
					OP_RENDER: predict_frame_samples();
					OP_LOCATE: position <= in_item.new_position;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				out_item_t want;
				if (expected_samples.size() == 0) begin
					$error("unexpected output item: channel %0d sample %0d",
						out_item.out_channel, out_item.out_sample);
					errs++;
				end else begin
					want = expected_samples.pop_front();
					if (out_item.out_channel !== want.out_channel) begin
						$error("out_channel: expected %0d, got %0d",
							want.out_channel, out_item.out_channel);
						errs++;
					end
					if (out_item.out_sample !== want.out_sample) begin
						$error("out_sample: expected %0d, got %0d",
							want.out_sample, out_item.out_sample);
						errs++;
					end
					if (out_item.written !== want.written) begin
						$error("written: expected %0d, got %0d", want.written, out_item.written);
						errs++;
					end
					if (out_item.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_item.last);
						errs++;
					end
				end
			end
			fails <= fails + errs;
			pending <= expected_samples.size();
		end
	end

endmodule

// ----- tb/sv/clip_player_with_linear_fades_test.sv -----
// Top of the clip player testbench: clock, reset, stimulus and verdict.
// Depends on cpf_pkg, the block and clip_player_with_linear_fades_checker.
module clip_player_with_linear_fades_test import cpf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk = 1'b0;
	logic        arst_n;
	in_item_t    in_item;
	logic        in_valid, in_stall;
	out_item_t   out_item;
	logic        out_valid, out_stall;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        cfg_valid, cfg_ready;
	int          pending, fails;
	int          cycles = 0;
	bit          hold_req = 0;
	bit          calm = 0;
	int          gap_calls = 0;

	logic [31:0] reg_mirror [8];
	logic [31:0] play_pos;
	bit          loaded [STORE_DEPTH];

	clip_player_with_linear_fades DUT (.*);

	clip_player_with_linear_fades_checker checker_i (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones, and stretches with none at all.
	function automatic int gap_len();
		int r;
		gap_calls++;
		if (gap_calls % 64 == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int n;
		out_stall <= 1'b0;
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (800) @(posedge clk);
				hold_req = 0;
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				n = gap_len();
				if (n == 0) begin
					out_stall <= 1'b0;
					@(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
					@(posedge clk);
				end
			end
		end
	end

	task automatic send(in_item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending and wait until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	task automatic set_reg(reg_idx_t idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GAIN:     reg_mirror[idx] = val & 32'hFFFF;
			REG_CLIP_LEN: reg_mirror[idx] = val & 32'h1FFFF;
			REG_CLIP_CH,
			REG_OUT_CH:   reg_mirror[idx] = val & 32'hF;
			default:      reg_mirror[idx] = val;
		endcase
	endtask

	task automatic setup(logic [31:0] st, logic [31:0] en, logic [31:0] fi, logic [31:0] fo,
			logic [31:0] g, logic [31:0] ln, logic [31:0] cc, logic [31:0] oc);
		drain();
		repeat (200) @(posedge clk);
		set_reg(REG_START, st);
		set_reg(REG_END, en);
		set_reg(REG_FADE_IN, fi);
		set_reg(REG_FADE_OUT, fo);
		set_reg(REG_GAIN, g);
		set_reg(REG_CLIP_LEN, ln);
		set_reg(REG_CLIP_CH, cc);
		set_reg(REG_OUT_CH, oc);
	endtask

	// Frame of clip memory that a render at pos would read, if any.
	function automatic bit frame_read(logic [31:0] pos, output int fr);
		longint unsigned st, en, ln, eff;
		ln = (reg_mirror[REG_CLIP_LEN] < CLIP_FRAMES) ? reg_mirror[REG_CLIP_LEN] : CLIP_FRAMES;
		st = reg_mirror[REG_START];
		en = (reg_mirror[REG_END] > st) ? reg_mirror[REG_END] : st;
		eff = (st + ln < en) ? st + ln : en;
		fr = int'(longint'(pos) - longint'(st));
		return ln != 0 && reg_mirror[REG_CLIP_CH] != 0 && pos >= st && pos < eff;
	endfunction

	task automatic load(int fr, int ch, logic [15:0] smp);
		in_item_t it;
		it = '0;
		it.operation = OP_LOAD;
		it.load_frame = 16'(fr);
		it.load_channel = 3'(ch);
		it.load_sample = smp;
		it.new_position = $urandom;
		send(it);
		if (ch < MAX_CHANNELS)
			loaded[fr * MAX_CHANNELS + ch] = 1;
	endtask

	// Fill the frame about to be played first, so no unloaded sample is read.
	task automatic render();
		in_item_t it;
		int fr;
		if (frame_read(play_pos, fr))
			for (int ch = 0; ch < MAX_CHANNELS; ch++)
				if (!loaded[fr * MAX_CHANNELS + ch])
					load(fr, ch, $urandom);
		it = $urandom;
		it.operation = OP_RENDER;
		send(it);
		play_pos++;
	endtask

	task automatic locate(logic [31:0] p);
		in_item_t it;
		it = '0;
		it.operation = OP_LOCATE;
		it.new_position = p;
		send(it);
		play_pos = p;
	endtask

	task automatic no_op();
		in_item_t it;
		it = {$urandom, $urandom};
		it.operation = OP_NONE;
		send(it);
	endtask

	task automatic random_phase(int n_items);
		logic [31:0] st, ln, r;
		st = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 50) : $urandom;
		r = $urandom_range(0, 9);
		ln = (r < 8) ? $urandom_range(1, 20) : ((r == 8) ? 0 : $urandom_range(0, 65536));
		setup(st, ($urandom_range(0, 4) == 0) ? $urandom : st + $urandom_range(0, 30),
			($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, ln + 3),
			($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, ln + 3),
			$urandom_range(0, 65535), ln, $urandom_range(0, 8),
			($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 4));
		locate(st - $urandom_range(0, 3));
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				render();
			else if (r < 80)
				load($urandom_range(0, 24), $urandom_range(0, 7), $urandom);
			else if (r < 86)
				load($urandom_range(0, 65535), $urandom_range(0, 7), $urandom);
			else if (r < 93)
				locate(st + $urandom_range(0, 24) - 2);
			else if (r < 97)
				locate($urandom);
			else
				no_op();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_item <= '0;
		in_valid <= 1'b0;
		cfg_index <= REG_START;
		cfg_data <= '0;
		cfg_valid <= 1'b0;
		reg_mirror = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd4096, 32'd0, 32'd0, 32'd2};
		play_pos = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty clip after reset: two unwritten results per frame.
		render();
		no_op();
		load(65535, 7, 16'h7FFF);
		locate(32'hFFFF_FFFF);
		render();
		render();

		// Short stereo clip with both fades; hold the receiver so the queue fills.
		setup(32'd100, 32'd120, 32'd5, 32'd4, 32'd4096, 32'd16, 32'd2, 32'd2);
		load(0, 0, 16'h8000);
		load(0, 1, 16'h7FFF);
		locate(32'd98);
		hold_req = 1;
		repeat (12) render();
		drain();

		// Mono clip to eight outputs, full negative gain, one-frame fades.
		setup(32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'h8000, 32'd8, 32'd1, 32'd8);
		locate(32'd0);
		repeat (3) render();

		// Window raised to start is empty; no results at all for zero outputs.
		setup(32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF, 32'd65536,
			32'd8, 32'd0);
		locate(32'hFFFF_FFF0);
		render();

		// Longest clip, clamped channel count, frames at the far end of memory.
		setup(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'h7FFF, 32'd65536, 32'd8, 32'd3);
		locate(32'd65533);
		repeat (4) render();

		for (int p = 0; p < 6; p++) begin
			random_phase(20);
			if (p == 2)
				drain();
		end

		drain();
		repeat (300) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
